// File: design/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Widths, request codes, status codes and register map of the frame bitmap
// allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	// Field widths
	localparam int ACT_W = 3;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int ST_W  = 3;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TOTAL_FRAMES = 1'b0;   // paddr top-bit value that selects total_frames

	// Bitmap storage: one memory row holds ROW_BITS usage bits
	localparam int ROW_BITS    = 8;
	localparam int ROW_SH      = 3;
	localparam int ROW_CNT_W   = CNT_W - ROW_SH + 1;
	localparam int TOTAL_LIMIT = 8192;        // total_frames never reaches this
	localparam int MAX_FRAMES_DEF = 4096;

	// Request codes
	localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MARK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNMARK = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TEST   = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK           = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_RUN       = 3'd1;
	localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd2;
	localparam logic [ST_W-1:0] ST_RANGE        = 3'd3;
	localparam logic [ST_W-1:0] ST_ZERO         = 3'd4;

endpackage

// File: design/frame_bitmap_allocator_top.sv
// Out-of-range, zero-count, oversize and unknown requests answer from idle;
// free, mark and test read one row and write it back (test skips the write).
// Allocate reads one 8-frame row per cycle to a fit or a miss, then marks the run.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: async, clears counters; then a clearing pass over all ceil(DEPTH/8) rows
// (512 by default, at most 1024) zeroes the bitmap with busy high.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit bitmap page-frame allocator with an APB register for the frame
// count and a row-serial scan/mark sequencer over a bitmap memory.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top #(
	parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            start,
	output logic                            busy,
	input  logic [fba_pkg::ACT_W-1:0]       action,
	input  logic [fba_pkg::IDX_W-1:0]       frame_index,
	input  logic [fba_pkg::CNT_W-1:0]       run_length,
	// result
	output logic                            done,
	output logic [fba_pkg::ST_W-1:0]        status,
	output logic [fba_pkg::IDX_W-1:0]       start_frame,
	output logic                            frame_in_use,
	output logic [fba_pkg::CNT_W-1:0]       used_frames,
	output logic [fba_pkg::CNT_W-1:0]       free_frames,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fba_pkg::ADDR_W-1:0]      paddr,
	input  logic [fba_pkg::DATA_W-1:0]      pwdata,
	output logic [fba_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	localparam int DEPTH = (MAX_FRAMES < fba_pkg::TOTAL_LIMIT) ? MAX_FRAMES
		: fba_pkg::TOTAL_LIMIT;
	localparam int ROWS  = (DEPTH + fba_pkg::ROW_BITS - 1) / fba_pkg::ROW_BITS;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = fba_pkg::CNT_W;
	localparam int RCW   = fba_pkg::ROW_CNT_W;
	localparam int PW    = CW + 1;
	localparam int RB    = fba_pkg::ROW_BITS;
	localparam logic [PW-1:0]  DEPTH_C    = PW'(DEPTH);
	localparam logic [RCW-1:0] LAST_ROW_C = RCW'(ROWS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_SGL_RD,
		S_SGL_WR,
		S_RESP
	} state_t;

	state_t state_q;

	logic [CW-1:0]  total_q;
	logic [CW-1:0]  t_q;
	logic [CW-1:0]  used_q;
	logic [fba_pkg::ACT_W-1:0] act_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  len_q;
	logic [CW-1:0]  run_q;
	logic [CW-1:0]  run_start_q;
	logic [CW-1:0]  mark_end_q;
	logic [RCW-1:0] rd_row_q;
	logic [RCW-1:0] row_s1;
	logic           rd_vld_s1;
	logic [RB-1:0]  rdata_s1;

	logic [fba_pkg::ST_W-1:0] res_status_q;
	logic [CW-1:0]  res_start_q;
	logic           res_inuse_q;

	logic                      done_q;
	logic [fba_pkg::ST_W-1:0]  status_q;
	logic [fba_pkg::IDX_W-1:0] start_frame_q;
	logic                      frame_in_use_q;
	logic [CW-1:0]             used_frames_q;
	logic [CW-1:0]             free_frames_q;

	logic [RB-1:0] mem [ROWS];

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	logic cfg_wr;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[fba_pkg::ADDR_W-1] == fba_pkg::REG_TOTAL_FRAMES);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? fba_pkg::DATA_W'(total_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_wr) begin
			total_q <= pwdata[CW-1:0];
		end
	end

	// effective total: register capped at the bitmap size
	logic [CW-1:0] t_eff_c;
	assign t_eff_c = ({1'b0, total_q} > DEPTH_C) ? DEPTH_C[CW-1:0] : total_q;

	// ------------------------------------------------------------------
	// Scan unit: walk one bitmap row, carry the free-run length across rows
	// ------------------------------------------------------------------
	logic [CW-1:0] run_c;
	logic [CW-1:0] rs_c;
	logic [CW-1:0] fstart_c;
	logic          found_c;
	logic [PW-1:0] pos_c;
	logic          last_row_c;

	always_comb begin
		run_c    = run_q;
		rs_c     = run_start_q;
		fstart_c = '0;
		found_c  = 1'b0;
		pos_c    = '0;
		for (int j = 0; j < RB; j++) begin
			pos_c = {row_s1, 3'(j)};
			if (!found_c && (pos_c < {1'b0, t_q})) begin
				if (rdata_s1[j]) begin
					run_c = '0;
					rs_c  = CW'(pos_c + PW'(1));
				end else begin
					run_c = run_c + CW'(1);
					if (run_c == len_q) begin
						found_c  = 1'b1;
						fstart_c = rs_c;
					end
				end
			end
		end
	end

	assign last_row_c = ({row_s1, 3'b111} >= ({1'b0, t_q} - PW'(1)));

	// ------------------------------------------------------------------
	// Mark unit: set the allocated bits of one row
	// ------------------------------------------------------------------
	logic [RB-1:0]  mark_mask_c;
	logic [RCW-1:0] end_row_c;
	logic [PW-1:0]  mpos_c;

	assign end_row_c = {1'b0, mark_end_q[CW-1:fba_pkg::ROW_SH]};

	always_comb begin
		mark_mask_c = '0;
		mpos_c      = '0;
		for (int j = 0; j < RB; j++) begin
			mpos_c = {row_s1, 3'(j)};
			mark_mask_c[j] = (mpos_c >= {1'b0, res_start_q}) &&
				(mpos_c <= {1'b0, mark_end_q});
		end
	end

	// ------------------------------------------------------------------
	// Memory port control
	// ------------------------------------------------------------------
	logic [RCW-1:0] srow_c;
	logic [RB-1:0]  sbit_c;
	logic           rd_en;
	logic [RCW-1:0] raddr;
	logic           we;
	logic [RCW-1:0] waddr;
	logic [RB-1:0]  wdata;
	logic           scan_issue;
	logic           mark_issue;

	assign srow_c     = {1'b0, idx_q[CW-1:fba_pkg::ROW_SH]};
	assign sbit_c     = RB'(1) << idx_q[fba_pkg::ROW_SH-1:0];
	assign scan_issue = ({rd_row_q, 3'b000} < {1'b0, t_q}) && !(rd_vld_s1 && found_c);
	assign mark_issue = (rd_row_q <= end_row_c);

	always_comb begin
		rd_en = 1'b0;
		raddr = rd_row_q;
		we    = 1'b0;
		waddr = rd_row_q;
		wdata = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_SCAN: begin
				rd_en = scan_issue;
			end
			S_MARK: begin
				rd_en = mark_issue;
				we    = rd_vld_s1;
				waddr = row_s1;
				wdata = rdata_s1 | mark_mask_c;
			end
			S_SGL_RD: begin
				rd_en = 1'b1;
				raddr = srow_c;
			end
			S_SGL_WR: begin
				we    = (act_q != fba_pkg::ACT_TEST);
				waddr = srow_c;
				wdata = (act_q == fba_pkg::ACT_MARK) ? (rdata_s1 | sbit_c)
					: (rdata_s1 & ~sbit_c);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[RW-1:0]] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr[RW-1:0]];
		end
		row_s1 <= raddr;
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic sold_c;
	assign sold_c = rdata_s1[idx_q[fba_pkg::ROW_SH-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			rd_row_q  <= '0;
			rd_vld_s1 <= 1'b0;
			used_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= rd_en;
			case (state_q)
				S_CLEAR: begin
					rd_row_q <= rd_row_q + RCW'(1);
					if (rd_row_q == LAST_ROW_C) begin
						rd_row_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q        <= action;
						idx_q        <= CW'(frame_index);
						len_q        <= run_length;
						t_q          <= t_eff_c;
						res_status_q <= fba_pkg::ST_OK;
						res_start_q  <= '0;
						res_inuse_q  <= 1'b0;
						rd_row_q     <= '0;
						run_q        <= '0;
						run_start_q  <= '0;
						state_q      <= S_RESP;
						case (action)
							fba_pkg::ACT_ALLOC: begin
								if (run_length == '0) begin
									res_status_q <= fba_pkg::ST_ZERO;
								end else if (run_length > t_eff_c) begin
									res_status_q <= fba_pkg::ST_NO_RUN;
								end else begin
									state_q <= S_SCAN;
								end
							end
							fba_pkg::ACT_FREE, fba_pkg::ACT_MARK,
							fba_pkg::ACT_UNMARK, fba_pkg::ACT_TEST: begin
								if (CW'(frame_index) >= t_eff_c) begin
									res_status_q <= fba_pkg::ST_RANGE;
								end else begin
									state_q <= S_SGL_RD;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						rd_row_q <= rd_row_q + RCW'(1);
					end
					if (rd_vld_s1) begin
						if (found_c) begin
							res_start_q <= fstart_c;
							mark_end_q  <= fstart_c + len_q - CW'(1);
							rd_row_q    <= {1'b0, fstart_c[CW-1:fba_pkg::ROW_SH]};
							state_q     <= S_MARK;
						end else if (last_row_c) begin
							res_status_q <= fba_pkg::ST_NO_RUN;
							state_q      <= S_RESP;
						end else begin
							run_q       <= run_c;
							run_start_q <= rs_c;
						end
					end
				end
				S_MARK: begin
					if (mark_issue) begin
						rd_row_q <= rd_row_q + RCW'(1);
					end
					if (rd_vld_s1 && (row_s1 == end_row_c)) begin
						used_q  <= used_q + len_q;
						state_q <= S_RESP;
					end
				end
				S_SGL_RD: begin
					state_q <= S_SGL_WR;
				end
				S_SGL_WR: begin
					res_inuse_q <= sold_c;
					case (act_q)
						fba_pkg::ACT_FREE: begin
							if (sold_c) begin
								used_q <= used_q - CW'(1);
							end else begin
								res_status_q <= fba_pkg::ST_ALREADY_FREE;
							end
						end
						fba_pkg::ACT_MARK: begin
							if (!sold_c) begin
								used_q <= used_q + CW'(1);
							end
						end
						fba_pkg::ACT_UNMARK: begin
							if (sold_c) begin
								used_q <= used_q - CW'(1);
							end
						end
						default: begin
							used_q <= used_q;
						end
					endcase
					state_q <= S_RESP;
				end
				S_RESP: begin
					done_q         <= 1'b1;
					status_q       <= res_status_q;
					start_frame_q  <= res_start_q[fba_pkg::IDX_W-1:0];
					frame_in_use_q <= res_inuse_q;
					used_frames_q  <= used_q;
					free_frames_q  <= (t_q > used_q) ? (t_q - used_q) : '0;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign start_frame  = start_frame_q;
	assign frame_in_use = frame_in_use_q;
	assign used_frames  = used_frames_q;
	assign free_frames  = free_frames_q;

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fba_pkg::ST_OK)) |-> (start_frame == '0))
		else $error("failed request reports a nonzero start frame");

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (free_frames != '0)) |->
		((PW'(free_frames) + PW'(used_frames)) == {1'b0, t_q}))
		else $error("used and free counts do not add up to the total");
`endif

endmodule

// File: tb/frame_bitmap_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top_tb
// Drives allocate, free, mark, unmark, test and reserved requests into the
// frame allocator under several frame totals set over APB. A predictor keeps
// its own usage bitmap and used count, and every result strobe is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_top_tb;

	localparam int MAX_FRAMES    = fba_pkg::MAX_FRAMES_DEF;
	localparam int CYCLE_LIMIT   = 6_000_000;
	localparam int SETTLE_CYCLES = 1100;

	localparam logic [fba_pkg::ACT_W-1:0]  ACT_RSVD_LO = 3'd5;
	localparam logic [fba_pkg::ACT_W-1:0]  ACT_RSVD_HI = 3'd7;
	localparam logic [fba_pkg::ADDR_W-1:0] TOTAL_FRAMES_ADDR =
		fba_pkg::ADDR_W'({fba_pkg::REG_TOTAL_FRAMES, 2'b00});
	localparam logic [fba_pkg::CNT_W-1:0]  CNT_FIELD_MAX = '1;
	localparam logic [fba_pkg::IDX_W-1:0]  IDX_FIELD_MAX = '1;

	typedef struct packed {
		logic [fba_pkg::ST_W-1:0]  status;
		logic [fba_pkg::IDX_W-1:0] start_frame;
		logic                      in_use;
		logic [fba_pkg::CNT_W-1:0] used;
		logic [fba_pkg::CNT_W-1:0] free;
	} frame_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [fba_pkg::ACT_W-1:0]  action;
	logic [fba_pkg::IDX_W-1:0]  frame_index;
	logic [fba_pkg::CNT_W-1:0]  run_length;
	logic                       done;
	logic [fba_pkg::ST_W-1:0]   status;
	logic [fba_pkg::IDX_W-1:0]  start_frame;
	logic                       frame_in_use;
	logic [fba_pkg::CNT_W-1:0]  used_frames;
	logic [fba_pkg::CNT_W-1:0]  free_frames;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [fba_pkg::ADDR_W-1:0] paddr;
	logic [fba_pkg::DATA_W-1:0] pwdata;
	logic [fba_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	// predictor state
	bit                        frame_used [MAX_FRAMES];
	int unsigned               used_total;
	logic [fba_pkg::CNT_W-1:0] total_frames_reg;

	frame_result_t pending_results [$];
	int unsigned   accepted_reqs;
	int unsigned   fail_cnt;
	int unsigned   cycle_cnt;

	frame_bitmap_allocator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.frame_index  (frame_index),
		.run_length   (run_length),
		.done         (done),
		.status       (status),
		.start_frame  (start_frame),
		.frame_in_use (frame_in_use),
		.used_frames  (used_frames),
		.free_frames  (free_frames),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("frame_bitmap_allocator_top test failed");
			$finish;
		end
	end

	function automatic int unsigned effective_span();
		return (total_frames_reg > MAX_FRAMES) ? MAX_FRAMES : 32'(total_frames_reg);
	endfunction

	// First-fit allocator behavior; updates the bitmap and the used count.
	function automatic frame_result_t compute_frame_result(
			input logic [fba_pkg::ACT_W-1:0] act,
			input logic [fba_pkg::IDX_W-1:0] idx, input logic [fba_pkg::CNT_W-1:0] len);
		frame_result_t res;
		int unsigned   span;
		int unsigned   run;
		int unsigned   first;
		int unsigned   i;
		bit            found;
		span   = effective_span();
		res    = '0;
		run    = 0;
		first  = 0;
		found  = 1'b0;
		if (act == fba_pkg::ACT_ALLOC) begin
			if (len == 0) begin
				res.status = fba_pkg::ST_ZERO;
			end else begin
				for (i = 0; i < span && !found; i++) begin
					run = frame_used[i] ? 0 : run + 1;
					if (run == len) begin
						first = i + 1 - 32'(len);
						found = 1'b1;
					end
				end
				if (found) begin
					for (i = first; i < first + len; i++)
						frame_used[i] = 1'b1;
					used_total     += 32'(len);
					res.start_frame = fba_pkg::IDX_W'(first);
				end else begin
					res.status = fba_pkg::ST_NO_RUN;
				end
			end
		end else if (act == fba_pkg::ACT_FREE || act == fba_pkg::ACT_MARK ||
				act == fba_pkg::ACT_UNMARK || act == fba_pkg::ACT_TEST) begin
			if (idx >= span) begin
				res.status = fba_pkg::ST_RANGE;
			end else begin
				res.in_use = frame_used[idx];
				if (act == fba_pkg::ACT_FREE) begin
					if (res.in_use) begin
						frame_used[idx] = 1'b0;
						used_total--;
					end else begin
						res.status = fba_pkg::ST_ALREADY_FREE;
					end
				end else if (act == fba_pkg::ACT_MARK && !res.in_use) begin
					frame_used[idx] = 1'b1;
					used_total++;
				end else if (act == fba_pkg::ACT_UNMARK && res.in_use) begin
					frame_used[idx] = 1'b0;
					used_total--;
				end
			end
		end
		res.used = fba_pkg::CNT_W'(used_total);
		res.free = (span > used_total) ? fba_pkg::CNT_W'(span - used_total) : '0;
		return res;
	endfunction

	// Check the result first: a strobe at an accept edge belongs to an older request.
	always @(posedge clk) begin
		frame_result_t exp_res;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				fail_cnt++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, status);
					fail_cnt++;
				end
				if (start_frame !== exp_res.start_frame) begin
					$error("start_frame: expected %0d, actual %0d",
						exp_res.start_frame, start_frame);
					fail_cnt++;
				end
				if (frame_in_use !== exp_res.in_use) begin
					$error("frame_in_use: expected %0d, actual %0d",
						exp_res.in_use, frame_in_use);
					fail_cnt++;
				end
				if (used_frames !== exp_res.used) begin
					$error("used_frames: expected %0d, actual %0d", exp_res.used, used_frames);
					fail_cnt++;
				end
				if (free_frames !== exp_res.free) begin
					$error("free_frames: expected %0d, actual %0d", exp_res.free, free_frames);
					fail_cnt++;
				end
			end
		end
		if (start && !busy) begin
			pending_results.push_back(compute_frame_result(action, frame_index, run_length));
			accepted_reqs++;
		end
	end

	// Start stays high on return so back-to-back requests need no drop.
	task automatic send_req(input logic [fba_pkg::ACT_W-1:0] act,
			input logic [fba_pkg::IDX_W-1:0] idx, input logic [fba_pkg::CNT_W-1:0] len);
		int unsigned seen;
		seen        = accepted_reqs;
		start       = 1'b1;
		action      = act;
		frame_index = idx;
		run_length  = len;
		do @(negedge clk); while (accepted_reqs == seen);
	endtask

	task automatic idle_for(input int unsigned n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	// Write total_frames, then read it back.
	task automatic write_total_frames(input logic [fba_pkg::CNT_W-1:0] value);
		wait_idle();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = TOTAL_FRAMES_ADDR;
		pwdata  = fba_pkg::DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		total_frames_reg = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== fba_pkg::DATA_W'(value)) begin
			$error("prdata: expected %0d, actual %0d", value, prdata);
			fail_cnt++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic test_zero_total();
		write_total_frames('0);
		send_req(fba_pkg::ACT_TEST, '0, '0);
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(1));
		send_req(fba_pkg::ACT_ALLOC, '0, '0);
		send_req(fba_pkg::ACT_FREE, IDX_FIELD_MAX, '0);
	endtask

	task automatic test_basic_requests();
		write_total_frames(fba_pkg::CNT_W'(16));
		send_req(fba_pkg::ACT_ALLOC, IDX_FIELD_MAX, '0);
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(1));
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(3));
		send_req(fba_pkg::ACT_TEST, fba_pkg::IDX_W'(2), '0);
		send_req(fba_pkg::ACT_FREE, '0, '0);
		send_req(fba_pkg::ACT_FREE, '0, '0);
		send_req(fba_pkg::ACT_MARK, '0, '0);
		send_req(fba_pkg::ACT_MARK, '0, CNT_FIELD_MAX);
		send_req(fba_pkg::ACT_UNMARK, fba_pkg::IDX_W'(9), '0);
		send_req(fba_pkg::ACT_UNMARK, '0, '0);
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(17));
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(12));
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(1));
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(1));
		send_req(fba_pkg::ACT_TEST, fba_pkg::IDX_W'(16), '0);
		send_req(fba_pkg::ACT_FREE, IDX_FIELD_MAX, '0);
		send_req(ACT_RSVD_LO, fba_pkg::IDX_W'(3), fba_pkg::CNT_W'(2));
		send_req(ACT_RSVD_LO + 3'd1, IDX_FIELD_MAX, CNT_FIELD_MAX);
		send_req(ACT_RSVD_HI, '0, fba_pkg::CNT_W'(1));
		send_req(fba_pkg::ACT_ALLOC, '0, CNT_FIELD_MAX);
		// shrink below the used frames: free count saturates
		write_total_frames(fba_pkg::CNT_W'(4));
		send_req(fba_pkg::ACT_TEST, fba_pkg::IDX_W'(3), '0);
		send_req(fba_pkg::ACT_MARK, fba_pkg::IDX_W'(4), '0);
	endtask

	task automatic test_total_cap();
		write_total_frames(CNT_FIELD_MAX);
		send_req(fba_pkg::ACT_TEST, IDX_FIELD_MAX, '0);
		send_req(fba_pkg::ACT_MARK, IDX_FIELD_MAX, '0);
		send_req(fba_pkg::ACT_ALLOC, '0, fba_pkg::CNT_W'(MAX_FRAMES));
		send_req(fba_pkg::ACT_FREE, IDX_FIELD_MAX, '0);
	endtask

	task automatic run_random_requests(input int unsigned n_reqs, input bit with_gaps,
			input bit pause_midway);
		int unsigned               n;
		int unsigned               span;
		int unsigned               pick;
		int unsigned               probe;
		int unsigned               alloc_pct;
		logic [fba_pkg::ACT_W-1:0] act;
		logic [fba_pkg::IDX_W-1:0] idx;
		logic [fba_pkg::CNT_W-1:0] len;
		for (n = 0; n < n_reqs; n++) begin
			if (pause_midway && n == n_reqs / 2)
				wait_idle();
			if (with_gaps && $urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 8));
			span      = effective_span();
			idx       = fba_pkg::IDX_W'($urandom_range(0, (1 << fba_pkg::IDX_W) - 1));
			len       = fba_pkg::CNT_W'($urandom_range(0, (1 << fba_pkg::CNT_W) - 1));
			// back off allocation once more than half the span is used
			alloc_pct = (used_total * 2 > span) ? 20 : 45;
			pick      = $urandom_range(0, 99);
			if (pick < alloc_pct) begin
				act   = fba_pkg::ACT_ALLOC;
				probe = $urandom_range(0, 19);
				if (probe < 14)
					len = fba_pkg::CNT_W'($urandom_range(1, 8));
				else if (probe < 18)
					len = fba_pkg::CNT_W'($urandom_range(1, span + 2));
				else if (probe == 18)
					len = '0;
			end else if (pick < alloc_pct + 25) begin
				act = fba_pkg::ACT_FREE;
				if (span > 0 && $urandom_range(0, 9) != 0) begin
					// aim at a used frame so most frees succeed
					idx = fba_pkg::IDX_W'($urandom_range(0, span - 1));
					for (probe = 0; probe < span && !frame_used[(idx + probe) % span]; probe++)
						;
					if (probe < span)
						idx = fba_pkg::IDX_W'((idx + probe) % span);
				end
			end else if (pick < 96) begin
				act = (pick % 3 == 0) ? fba_pkg::ACT_MARK
					: (pick % 3 == 1) ? fba_pkg::ACT_UNMARK : fba_pkg::ACT_TEST;
				if (span > 0 && $urandom_range(0, 6) != 0)
					idx = fba_pkg::IDX_W'($urandom_range(0, span - 1));
			end else begin
				act = fba_pkg::ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
			end
			send_req(act, idx, len);
		end
	endtask

	task automatic test_random_mix();
		write_total_frames(fba_pkg::CNT_W'(64));
		run_random_requests(300, 1'b1, 1'b0);
		write_total_frames(fba_pkg::CNT_W'(1));
		run_random_requests(50, 1'b1, 1'b0);
		write_total_frames(fba_pkg::CNT_W'(200));
		run_random_requests(350, 1'b1, 1'b1);
		write_total_frames(fba_pkg::CNT_W'(MAX_FRAMES));
		run_random_requests(200, 1'b1, 1'b0);
		write_total_frames(fba_pkg::CNT_W'(37));
		run_random_requests(200, 1'b1, 1'b0);
		// no gaps in the closing stretch
		write_total_frames(fba_pkg::CNT_W'(MAX_FRAMES + 1));
		run_random_requests(200, 1'b0, 1'b0);
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		action           = fba_pkg::ACT_ALLOC;
		frame_index      = '0;
		run_length       = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		total_frames_reg = '0;
		used_total       = 0;
		accepted_reqs    = 0;
		fail_cnt         = 0;
		cycle_cnt        = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_zero_total();
		test_basic_requests();
		test_total_cap();
		test_random_mix();

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_cnt == 0 && pending_results.size() == 0)
			$display("frame_bitmap_allocator_top test passed");
		else
			$display("frame_bitmap_allocator_top test failed");
		$finish;
	end

endmodule
